@@ design/fixed_block_pool_allocator_macros.svh @@
// Assertion macros shared by the checker of the pool allocator.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Checked at every rising edge outside reset.
`define FBPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FBPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/fbpa_pkg.sv @@
// Shared constants and types for the fixed block pool allocator.
// Used by the link memory, the top level and the checker; depends on nothing.
package fbpa_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int CNT_W         = 11;
  localparam int IDX_W         = 10;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int S_DATA_W      = 16;
  localparam int M_DATA_W      = 24;
  localparam int MIN_ENTRIES   = 2;
  localparam int ENTRY_RESET   = 1024;

  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

  typedef enum logic [1:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_EXEC,
    FSM_CLEAR
  } fsm_t;

endpackage

@@ design/fbpa_link_ram.sv @@
// Link memory of the free list: one write port, one read port, registered read.
// Depends on fbpa_pkg for the default depth.
module fbpa_link_ram
  import fbpa_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int IW    = $clog2(DEPTH),
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [LW-1:0] wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output logic [LW-1:0] rdata
);

  logic [LW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator: a linked free list kept in a synchronous memory.
// Depends on fbpa_pkg and fbpa_link_ram.
//
// Requests arrive on the s_ stream, one beat each: allocate pops the head of
// the free list, free pushes an index at the head, clear rebuilds the list as
// 0,1,...,n-1 with n the entry count clamped to 2..DEPTH. Each request gives
// one result beat on the m_ stream with the allocated index, a status and the
// in-use count. The cfg channel writes the entry count, which sizes the list
// at the next clear and bounds free indices at once; it is always ready.
// Allocate and free: the accept cycle reads the head entry's link from the
// link memory, then the EXEC state commits and loads the output register once
// the output slot is free; no new request is taken before that. Clear then
// rewrites n links, one per cycle, during which no request is taken.
// After reset the block walks all DEPTH links, one per cycle, before it
// raises s_tready. The result sits in an output register; a new request is
// taken while it waits, but that request does not commit until the receiver
// has taken the pending beat.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // opcode[1:0], free_index[11:2], zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // alloc_index[9:0], status[11:10],
                                        // in_use_count[22:12], zero pad
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CNT_W-1:0]    cfg_data
);

  localparam int IW      = $clog2(DEPTH);
  localparam int LW      = $clog2(DEPTH + 1);
  localparam int W       = (LW > CNT_W) ? LW : CNT_W;
  localparam int N_RESET = (DEPTH < ENTRY_RESET) ? DEPTH : ENTRY_RESET;
  localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);

  fsm_t state, state_next;

  logic [OP_W-1:0]  op_q, op_q_next;
  logic [IDX_W-1:0] idx_q, idx_q_next;
  logic [LW-1:0]    head, head_next;
  logic [CNT_W-1:0] used, used_next;
  logic [CNT_W-1:0] entry_count;
  logic [IW-1:0]    sweep_cnt, sweep_cnt_next;
  logic [IW-1:0]    sweep_end, sweep_end_next;
  logic [IW-1:0]    link_end, link_end_next;
  logic             out_valid, out_valid_next;
  logic [M_DATA_W-1:0] out_data, out_data_next;

  logic          accept;
  logic          slot_free;
  logic [W-1:0]  count_w;
  logic [W-1:0]  eff_count;
  logic [W-1:0]  idx_w;
  logic [W-1:0]  given_w;
  logic [IDX_W-1:0]    given;
  logic [STATUS_W-1:0] status;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [LW-1:0] mem_rdata;

  assign s_tready  = (state == FSM_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign cfg_ready = 1'b1;

  assign count_w = W'(entry_count);
  assign idx_w   = W'(idx_q);

  always_comb begin
    if (count_w < W'(MIN_ENTRIES)) begin
      eff_count = W'(MIN_ENTRIES);
    end else if (count_w > W'(DEPTH)) begin
      eff_count = W'(DEPTH);
    end else begin
      eff_count = count_w;
    end
  end

  fbpa_link_ram #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .LW    (LW)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (head[IW-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next     = state;
    op_q_next      = op_q;
    idx_q_next     = idx_q;
    head_next      = head;
    used_next      = used;
    sweep_cnt_next = sweep_cnt;
    sweep_end_next = sweep_end;
    link_end_next  = link_end;
    out_valid_next = out_valid && !m_tready;
    out_data_next  = out_data;
    mem_we         = 1'b0;
    mem_waddr      = sweep_cnt;
    mem_wdata      = NULL_LINK;
    given_w        = '0;
    status         = ST_OK;

    case (state)
      FSM_INIT, FSM_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt;
        if (sweep_cnt == link_end || sweep_cnt == IW'(DEPTH - 1)) begin
          mem_wdata = NULL_LINK;
        end else begin
          mem_wdata = LW'(sweep_cnt) + LW'(1);
        end
        if (sweep_cnt == sweep_end) begin
          state_next = FSM_IDLE;
        end else begin
          sweep_cnt_next = sweep_cnt + IW'(1);
        end
      end
      FSM_IDLE: begin
        if (accept) begin
          op_q_next  = s_tdata[OP_W-1:0];
          idx_q_next = s_tdata[OP_W+IDX_W-1:OP_W];
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (slot_free) begin
          state_next = FSM_IDLE;
          case (op_q)
            OP_ALLOC: begin
              if (head >= NULL_LINK) begin
                status = ST_EXHAUSTED;
              end else begin
                given_w   = W'(head);
                head_next = mem_rdata;
                if (used != COUNT_MAX) begin
                  used_next = used + CNT_W'(1);
                end
              end
            end
            OP_FREE: begin
              if (idx_w >= eff_count) begin
                status = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_w[IW-1:0];
                mem_wdata = head;
                head_next = idx_w[LW-1:0];
                if (used != '0) begin
                  used_next = used - CNT_W'(1);
                end
              end
            end
            OP_CLEAR: begin
              head_next      = '0;
              used_next      = '0;
              sweep_cnt_next = '0;
              sweep_end_next = eff_count[IW-1:0] - IW'(1);
              link_end_next  = eff_count[IW-1:0] - IW'(1);
              state_next     = FSM_CLEAR;
            end
            default: begin
              status = ST_OK;
            end
          endcase
          out_valid_next = 1'b1;
          out_data_next  = M_DATA_W'({used_next, status, given});
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  assign given = given_w[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FSM_INIT;
      head        <= '0;
      used        <= '0;
      entry_count <= CNT_W'(ENTRY_RESET);
      sweep_cnt   <= '0;
      sweep_end   <= IW'(DEPTH - 1);
      link_end    <= IW'(N_RESET - 1);
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      used      <= used_next;
      sweep_cnt <= sweep_cnt_next;
      sweep_end <= sweep_end_next;
      link_end  <= link_end_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_q_next;
    idx_q    <= idx_q_next;
    out_data <= out_data_next;
  end

endmodule

@@ design/fbpa_checker.sv @@
// Port-level checker for the pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_macros.svh.
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_checker
  import fbpa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  `FBPA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `FBPA_ASSERT(a_status_code, m_tvalid |-> m_tdata[11:10] != ST_UNUSED, "undefined status code")
  `FBPA_ASSERT(a_err_no_index, m_tvalid && m_tdata[11:10] != ST_OK |-> m_tdata[9:0] == '0, "index given on an error")
  `FBPA_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid && !s_tready, "activity right after reset")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ bench/tb.sv @@
// Self-checking testbench for fixed_block_pool_allocator: random and directed requests,
// with a free-list predictor in a scoreboard class. Depends on fbpa_pkg and the RTL top.
module tb;
  import fbpa_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 165;
  localparam int HOLD_CYCLES = 400;
  localparam int SATURATE_ALLOCS = 20;

  typedef struct packed {
    logic [IDX_W-1:0]    alloc_index;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    in_use_count;
  } pool_reply_t;

  class pool_scoreboard;
    logic [CNT_W-1:0] link_mem [DEPTH_DEFAULT];
    logic [CNT_W-1:0] head_slot;
    logic [CNT_W-1:0] used_total;
    logic [CNT_W-1:0] entry_count;
    pool_reply_t      replies_due[$];
    int failures, reported, requests, results, exhausted_seen, range_seen, peak_in_use;

    function new();
      entry_count = CNT_W'(ENTRY_RESET);
      for (int i = 0; i < DEPTH_DEFAULT; i++) link_mem[i] = CNT_W'(i + 1);
      rebuild_list();
    endfunction

    function int active_entries();
      if (entry_count < MIN_ENTRIES) return MIN_ENTRIES;
      if (entry_count > DEPTH_DEFAULT) return DEPTH_DEFAULT;
      return int'(entry_count);
    endfunction

    function void rebuild_list();
      int n;
      n = active_entries();
      for (int i = 0; i + 1 < n; i++) link_mem[i] = CNT_W'(i + 1);
      link_mem[n - 1] = CNT_W'(DEPTH_DEFAULT);
      head_slot = '0;
      used_total = '0;
    endfunction

    function void set_entry_count(logic [CNT_W-1:0] value);
      entry_count = value;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void note_request(logic [S_DATA_W-1:0] beat);
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      pool_reply_t      reply;
      op = beat[OP_W-1:0];
      idx = beat[OP_W +: IDX_W];
      reply = '0;
      requests++;
      case (op)
        OP_ALLOC: begin
          if (head_slot >= DEPTH_DEFAULT) begin
            reply.status = ST_EXHAUSTED;
            exhausted_seen++;
          end else begin
            reply.alloc_index = head_slot[IDX_W-1:0];
            head_slot = link_mem[head_slot];
            if (used_total < COUNT_MAX) used_total++;
          end
        end
        OP_FREE: begin
          if (idx >= active_entries()) begin
            reply.status = ST_RANGE;
            range_seen++;
          end else begin
            link_mem[idx] = head_slot;
            head_slot = CNT_W'(idx);
            if (used_total > 0) used_total--;
          end
        end
        OP_CLEAR: begin
          rebuild_list();
        end
        default: begin
        end
      endcase
      reply.in_use_count = used_total;
      if (used_total > peak_in_use) peak_in_use = used_total;
      replies_due.push_back(reply);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        failures++;
        if (reported < 10) begin
          $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                   name, results, want, got);
          reported++;
        end
      end
    endfunction

    function void check_result(logic [M_DATA_W-1:0] beat);
      pool_reply_t want;
      pool_reply_t got;
      got.alloc_index = beat[IDX_W-1:0];
      got.status = beat[IDX_W +: STATUS_W];
      got.in_use_count = beat[IDX_W + STATUS_W +: CNT_W];
      results++;
      if (replies_due.size() == 0) begin
        failures++;
        if (reported < 10) begin
          $display("Result %0d arrived with no request outstanding", results);
          reported++;
        end
        return;
      end
      want = replies_due.pop_front();
      compare_field("alloc_index", want.alloc_index, got.alloc_index);
      compare_field("status", want.status, got.status);
      compare_field("in_use_count", want.in_use_count, got.in_use_count);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_W-1:0]    cfg_data = '0;

  pool_scoreboard sb;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  idle_cycles = 0;
  bit  hold_request = 1'b0;

  fixed_block_pool_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) sb.set_entry_count(cfg_data);
      if (s_tvalid && s_tready) sb.note_request(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request && stall_left == 0) begin
        stall_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_DATA_W - OP_W - IDX_W){1'b0}}, idx, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    int               r;
    int               n;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    n = sb.active_entries();
    r = $urandom_range(99);
    if (r < 47) op = OP_ALLOC;
    else if (r < 87) op = OP_FREE;
    else if (r < 94) op = OP_CLEAR;
    else op = OP_SPARE;
    r = $urandom_range(99);
    if (r < 80) idx = IDX_W'($urandom_range(n - 1, 0));
    else if (r < 95 && n < DEPTH_DEFAULT) idx = IDX_W'($urandom_range(DEPTH_DEFAULT - 1, n));
    else idx = IDX_W'($urandom_range(DEPTH_DEFAULT - 1, 0));
    send_request(op, idx);
  endtask

  initial begin : stimulus
    int phase_counts[6];
    phase_counts = '{5, 0, 2047, 17, 64, 3};
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 30;
    rx_idle_pct = 69;
    write_entry_count(CNT_W'(ENTRY_RESET));
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 10'd1);
    send_request(OP_FREE, 10'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 10'd1023);
    send_request(OP_ALLOC, '0);
    send_request(OP_SPARE, 10'd1023);
    send_request(OP_CLEAR, '1);
    send_request(OP_FREE, 10'd5);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    drain_results();
    write_entry_count('0);
    send_request(OP_CLEAR, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 10'd2);
    send_request(OP_FREE, 10'd1023);
    send_request(OP_FREE, 10'd1);
    send_request(OP_ALLOC, '0);

    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p < 2) ? 30 : (p < 4) ? 69 : 0;
      rx_idle_pct = (p < 2) ? 69 : (p < 4) ? 30 : 0;
      drain_results();
      write_entry_count(CNT_W'(phase_counts[p]));
      send_request(OP_CLEAR, '0);
      if (p == 4) hold_request = 1'b1;
      repeat (RANDOM_PER_PHASE) random_request();
    end

    // Freeing entry 0 onto itself makes every later allocate return it, a
    // double free that the pool does not catch.
    drain_results();
    write_entry_count(CNT_W'(MIN_ENTRIES));
    send_request(OP_CLEAR, '0);
    send_request(OP_FREE, '0);
    send_request(OP_FREE, '0);
    repeat (SATURATE_ALLOCS) send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 10'd1);

    drain_results();
    repeat (40) @(posedge clk);
    $display("Pool run covered %0d requests and %0d results over entry counts 0 to 2047.",
             sb.requests, sb.results);
    $display("Exhausted pools: %0d, out of range frees: %0d, peak in-use count: %0d.",
             sb.exhausted_seen, sb.range_seen, sb.peak_in_use);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("Failures: %0d, results still outstanding: %0d", sb.failures, sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
